// ===== src/ovb_pkg.sv =====
package ovb_pkg;

	typedef logic [2:0]         op_t;
	typedef logic signed [31:0] value_t;

	localparam op_t OP_SET_MODE = 3'd0;
	localparam op_t OP_NUMBER   = 3'd1;
	localparam op_t OP_DUMP     = 3'd2;
	localparam op_t OP_CUT      = 3'd3;
	localparam op_t OP_CLEAR    = 3'd4;

endpackage

// ===== src/ovb_in_if.sv =====
interface ovb_in_if import ovb_pkg::*; ();

	logic   valid;
	logic   ready;
	op_t    operation;
	value_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);

endinterface

// ===== src/ovb_out_if.sv =====
interface ovb_out_if import ovb_pkg::*; ();

	logic   valid;
	logic   ready;
	value_t out_value;
	logic   last;
	logic   dropped_full;

	modport source (output valid, output out_value, output last, output dropped_full,
		input ready);
	modport sink (input valid, input out_value, input last, input dropped_full,
		output ready);

endinterface

// ===== src/ordered_value_bag_unit.sv =====
// Insertion-ordered bag of signed 32-bit values, newest first, held in a single
// RAM of CAPACITY entries used as a ring (oldest entry at the base pointer).
// Items are taken one at a time; cmd.ready is low while an item is at work.
// Set mode and clear finish in idle; an insert without a duplicate check
// passes through the insert state alone. Every other item is paced by the
// RAM's single registered read port: a search takes a read and a compare
// step per entry visited, removing an entry reads and writes each younger
// entry to move it down, dump reads and loads each entry and cut the oldest
// one; dump, cut and a dropped insert also wait while the result side holds
// result.ready low. An insert into a full store is dropped and reported by
// one result with dropped_full set. The user writes allow_duplicates through
// cfg_we/cfg_data only while the block is idle; the block does not enforce it.
module ordered_value_bag_unit import ovb_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	ovb_in_if.sink           cmd,
	ovb_out_if.source        result,
	input  logic             cfg_we,
	input  logic             cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_W  = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_P = AW'(CAPACITY - 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SEARCH = 4'd1;
	localparam logic [3:0] S_CMP    = 4'd2;
	localparam logic [3:0] S_INSERT = 4'd3;
	localparam logic [3:0] S_SHRD   = 4'd4;
	localparam logic [3:0] S_SHWR   = 4'd5;
	localparam logic [3:0] S_READ   = 4'd6;
	localparam logic [3:0] S_LOAD   = 4'd7;

	logic [3:0]    state_q;
	op_t           op_q;
	value_t        val_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] base_q;
	logic          add_mode_q;
	logic          allow_dup_q;
	logic          out_valid_q;
	value_t        out_value_q;
	logic          out_last_q;
	logic          out_full_q;

	logic [CW-1:0] cnt_m1;
	logic [AW-1:0] ridx;
	logic [AW:0]   rsum;
	logic [AW-1:0] raddr;
	logic [AW-1:0] widx;
	logic [AW:0]   wsum;
	logic [AW-1:0] waddr;
	logic          we;
	logic [31:0]   wdata;
	logic [31:0]   rdata;
	logic          out_free;
	logic          out_load;
	value_t        load_value;
	logic          load_last;
	logic          load_full;
	logic          hit;

	assign cnt_m1   = count_q - 1'b1;
	assign out_free = !out_valid_q || result.ready;
	assign hit      = (rdata == $unsigned(val_q));

	assign ridx  = (state_q == S_SHRD) ? idx_q + 1'b1 : idx_q;
	assign rsum  = {1'b0, base_q} + {1'b0, ridx};
	assign raddr = (rsum >= CAP_W) ? AW'(rsum - CAP_W) : rsum[AW-1:0];

	assign widx  = (state_q == S_INSERT) ? count_q[AW-1:0] : idx_q;
	assign wsum  = {1'b0, base_q} + {1'b0, widx};
	assign waddr = (wsum >= CAP_W) ? AW'(wsum - CAP_W) : wsum[AW-1:0];

	assign we    = ((state_q == S_INSERT) && (count_q != CAP_C)) || (state_q == S_SHWR);
	assign wdata = (state_q == S_INSERT) ? $unsigned(val_q) : rdata;

	ovb_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		out_load   = 1'b0;
		load_value = '0;
		load_last  = 1'b0;
		load_full  = 1'b0;
		if (out_free) begin
			if (state_q == S_INSERT && count_q == CAP_C) begin
				out_load  = 1'b1;
				load_last = 1'b1;
				load_full = 1'b1;
			end else if (state_q == S_LOAD) begin
				out_load   = 1'b1;
				load_value = value_t'(rdata);
				load_last  = (op_q == OP_CUT) || (idx_q == '0);
			end
		end
	end

	assign cmd.ready           = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.out_value    = out_value_q;
	assign result.last         = out_last_q;
	assign result.dropped_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_dup_q <= 1'b0;
		end else if (cfg_we) begin
			allow_dup_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= load_value;
			out_last_q  <= load_last;
			out_full_q  <= load_full;
		end
		if (state_q == S_IDLE && cmd.valid) begin
			op_q  <= cmd.operation;
			val_q <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			base_q      <= '0;
			add_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						unique case (cmd.operation)
							OP_SET_MODE: begin
								add_mode_q <= (cmd.value != '0);
							end
							OP_NUMBER: begin
								idx_q <= cnt_m1[AW-1:0];
								if (count_q != '0 && !(add_mode_q && allow_dup_q)) begin
									state_q <= S_SEARCH;
								end else if (add_mode_q) begin
									state_q <= S_INSERT;
								end
							end
							OP_DUMP: begin
								idx_q <= cnt_m1[AW-1:0];
								if (count_q != '0) begin
									state_q <= S_READ;
								end
							end
							OP_CUT: begin
								idx_q <= '0;
								if (count_q != '0) begin
									state_q <= S_READ;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (hit) begin
						if (add_mode_q) begin
							state_q <= S_IDLE;
						end else if (CW'(idx_q) == cnt_m1) begin
							count_q <= cnt_m1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SHRD;
						end
					end else if (idx_q == '0) begin
						state_q <= add_mode_q ? S_INSERT : S_IDLE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= S_SEARCH;
					end
				end
				S_INSERT: begin
					if (count_q != CAP_C) begin
						count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SHRD: begin
					state_q <= S_SHWR;
				end
				S_SHWR: begin
					if (CW'(idx_q) + CW'(2) == count_q) begin
						count_q <= cnt_m1;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SHRD;
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						if (op_q == OP_CUT) begin
							base_q  <= (base_q == LAST_P) ? '0 : base_q + 1'b1;
							count_q <= cnt_m1;
							state_q <= S_IDLE;
						end else if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.dropped_full |-> result.out_value == '0 && result.last)
		else $error("overflow report carries a value");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_INSERT) || (state_q == S_SHWR))
		else $error("RAM written outside insert or shift");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.operation == OP_CLEAR |=> count_q == '0)
		else $error("clear left entries behind");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHRD |-> CW'(idx_q) + CW'(1) < count_q)
		else $error("shift read beyond newest entry");

endmodule

// ===== src/ovb_ram.sv =====
module ovb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
